FILE: rtl/core/sha256s_pkg.sv
// sha256s_pkg: shared types, constants and functions of the sha-256 stream hasher
// no dependencies
`default_nettype none
package sha256s_pkg;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } sha_state_t;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef logic [31:0] word_t;

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t ror32(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256s_in_if.sv
// sha256s_in_if: request channel carrying message bytes and finish requests
// no dependencies
`default_nettype none
interface sha256s_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    modport source (output valid, output mode, output data_byte, input ready);
    modport sink (input valid, input mode, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha256s_out_if.sv
// sha256s_out_if: result channel carrying digest words
// no dependencies
`default_nettype none
interface sha256s_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sha256_stream_hasher_top.sv
// sha256_stream_hasher_top: byte-serial sha-256 hasher with one shared round unit
// depends on sha256s_pkg, sha256s_in_if, sha256s_out_if
//
// usage
// - in_ch takes one request per byte: mode 0 absorbs data_byte, mode 1 finishes
//   the message and starts padding
// - out_ch returns eight digest words, index 0 first, last_word on index 7
// - in_ch.ready is high only while the sequencer is idle
// - the 64th absorbed byte of a block starts the rounds and then the chaining
//   add; no further byte is taken until the add is done
// - a finish request writes the padding one byte a cycle (plus a second block
//   when fewer than nine bytes are free), runs the rounds for each completed
//   block, then shows the digest words one per cycle while out_ch.ready is high
// - the round unit is a single sha-256 round, reused 64 times per block
// - if the receiver stalls, the current digest word is held and nothing else
//   moves; no new request is taken until the last word has gone
// - reset loads the initial hash values and clears the byte and length counts
// - after the last word the block returns to the initial hash for the next message
`default_nettype none
module sha256_stream_hasher_top (
    input  wire           clk,
    input  wire           rst_n,
    sha256s_in_if.sink    in_ch,
    sha256s_out_if.source out_ch
);
    import sha256s_pkg::*;

    sha_state_t   state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [60:0]  msg_reg, msg_next;
    logic [63:0]  bits_reg, bits_next;
    logic         first_reg, first_next;     // next pad byte is the 0x80 marker
    logic         len_reg, len_next;         // length bytes are being written
    logic         fin_reg, fin_next;         // after the rounds, show the digest
    logic         pad_mode_reg, pad_mode_next; // set while a finish request is being padded
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    logic [511:0] blk_reg, blk_next;         // 16 schedule words, word 0 on top
    word_t        hash_reg [8];
    word_t        hash_next [8];
    word_t        v_reg [8];
    word_t        v_next [8];

    // shared round unit
    word_t w0, w1, w9, w14, s0, s1, new_w, big0, big1, ch, maj, t1, t2;
    logic [7:0] pad_byte;
    logic [2:0] len_sel;

    always_comb
    begin
        w0    = blk_reg[511:480];
        w1    = blk_reg[479:448];
        w9    = blk_reg[223:192];
        w14   = blk_reg[63:32];
        s0    = ror32(w1, 7) ^ ror32(w1, 18) ^ (w1 >> 3);
        s1    = ror32(w14, 17) ^ ror32(w14, 19) ^ (w14 >> 10);
        new_w = w0 + s0 + w9 + s1;
        big1  = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + ROUND_K[rnd_reg] + w0;
        big0  = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
    end

    // length byte picked by position in the last eight bytes, most significant first
    always_comb
    begin
        len_sel = fill_reg[2:0];
        pad_byte = bits_reg[8'd63 - {2'b00, len_sel, 3'b000} -: 8];
        if (first_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (!len_reg && fill_reg != LEN_START)
        begin
            pad_byte = 8'h00;
        end
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = (state_reg == ST_OUT);
    assign out_ch.digest_word = hash_reg[idx_reg];
    assign out_ch.word_index  = idx_reg;
    assign out_ch.last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        msg_next   = msg_reg;
        bits_next  = bits_reg;
        first_next = first_reg;
        len_next   = len_reg;
        fin_next   = fin_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        blk_next   = blk_reg;
        hash_next  = hash_reg;
        v_next     = v_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (!in_ch.mode)
                    begin
                        blk_next  = {blk_reg[503:0], in_ch.data_byte};
                        fill_next = fill_reg + 6'd1;
                        msg_next  = msg_reg + 61'd1;
                        fin_next  = 1'b0;
                        if (fill_reg == 6'd63)
                        begin
                            v_next     = hash_reg;
                            rnd_next   = 6'd0;
                            state_next = ST_ROUND;
                        end
                    end
                    else
                    begin
                        bits_next  = {msg_reg, 3'b000};
                        first_next = 1'b1;
                        len_next   = 1'b0;
                        fin_next   = 1'b0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                blk_next   = {blk_reg[503:0], pad_byte};
                fill_next  = fill_reg + 6'd1;
                first_next = 1'b0;
                if (!first_reg && (len_reg || fill_reg == LEN_START))
                begin
                    len_next = 1'b1;
                end
                if (fill_reg == 6'd63)
                begin
                    fin_next   = !first_reg && len_reg;
                    v_next     = hash_reg;
                    rnd_next   = 6'd0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                blk_next  = {blk_reg[479:0], new_w};
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                if (fin_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
                else if (pad_mode_reg)
                begin
                    // a block filled during padding but not holding the length
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            hash_next[i] = init_hash(3'(i));
                        end
                        fill_next  = 6'd0;
                        msg_next   = 61'd0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pad_mode_next = pad_mode_reg;
        if (state_reg == ST_IDLE && in_ch.valid && in_ch.mode)
        begin
            pad_mode_next = 1'b1;
        end
        else if (state_reg == ST_OUT)
        begin
            pad_mode_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 6'd0;
            msg_reg      <= 61'd0;
            first_reg    <= 1'b0;
            len_reg      <= 1'b0;
            fin_reg      <= 1'b0;
            pad_mode_reg <= 1'b0;
            rnd_reg      <= 6'd0;
            idx_reg      <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            msg_reg      <= msg_next;
            first_reg    <= first_next;
            len_reg      <= len_next;
            fin_reg      <= fin_next;
            pad_mode_reg <= pad_mode_next;
            rnd_reg      <= rnd_next;
            idx_reg      <= idx_next;
            hash_reg     <= hash_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        bits_reg <= bits_next;
        v_reg    <= v_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("request accepted while digest pending");
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_word) |=> in_ch.ready)
        else $error("not idle after last digest word");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("round sequence broken");
    a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> (out_ch.word_index == 3'd0 && fill_reg == 6'd0))
        else $error("digest shown before padding ended");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_sha256s_types.sv
`timescale 1ns / 1ps
// tb_sha256s_types: bench-side request codes and digest record
// depends on nothing
package tb_sha256s_types;

    typedef enum logic {
        REQ_ABSORB = 1'b0,
        REQ_FINISH = 1'b1
    } req_mode_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_rec_t;

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for the sha-256 stream hasher, with a local sha-256 digest predictor
// depends on sha256s_pkg, sha256s_in_if, sha256s_out_if, tb_sha256s_types, sha256_stream_hasher_top
module tb_top;
    import sha256s_pkg::*;
    import tb_sha256s_types::*;

    // sha-256 round constants, held locally for the predictor
    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // digest of the empty message, first word
    localparam logic [31:0] EMPTY_W0 = 32'he3b0c442;

    // message lengths around the padding boundaries
    localparam int EDGE_LENS [5] = '{55, 56, 63, 64, 65};

    logic clk;
    logic rst_n;

    sha256s_in_if  in_ch ();
    sha256s_out_if out_ch ();

    sha256_stream_hasher_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // predictor state: chained hash, block buffer, fill and length counts
    logic [31:0] chain_h [8];
    logic [7:0]  blk_buf [64];
    logic [5:0]  fill_cnt;
    logic [60:0] msg_len;

    digest_rec_t digest_q [$];
    int          fail_cnt;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one 64-round compression of blk_buf into chain_h
    task automatic compress_buf();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                    chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + RK[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic buf_byte(input logic [7:0] b);
        blk_buf[fill_cnt] = b;
        fill_cnt++;
        if (fill_cnt == 0)
            compress_buf();
    endtask

    task automatic clear_hash();
        for (int i = 0; i < 8; i++)
            chain_h[i] = IV[i];
        fill_cnt = 0;
        msg_len  = 0;
    endtask

    // predictor: absorb a byte, or pad and queue the eight digest words
    task automatic predict_digest(input req_mode_t m, input logic [7:0] b);
        logic [63:0] bit_len;
        if (m == REQ_ABSORB)
        begin
            buf_byte(b);
            msg_len++;
            return;
        end
        bit_len = {msg_len, 3'b000};
        buf_byte(PAD_BYTE);
        while (fill_cnt != LEN_START)
            buf_byte(8'h00);
        for (int i = 0; i < 8; i++)
            buf_byte(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++)
            digest_q.push_back('{chain_h[i], 3'(i), i == 7});
        clear_hash();
    endtask

    // clock and one reset at the start
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // directed table; a typed-in first word is checked on top of the predictor
    typedef struct {
        req_mode_t   m;
        logic [7:0]  b;
        bit          has_w0;
        logic [31:0] w0;
    } stim_row_t;

    stim_row_t dir_tab [$];
    bit        typed_chk [$];
    logic [31:0] typed_w0 [$];

    // drive one request, holding valid until the block takes it;
    // with no gap, valid stays high and only the payload changes
    task automatic send_req(input req_mode_t m, input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= m;
        in_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_digest(m, b);
    endtask

    // sender goes quiet until every expected digest word is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int n_items, len;
        in_ch.valid     = 1'b0;
        in_ch.mode      = REQ_ABSORB;
        in_ch.data_byte = 8'h00;
        fail_cnt  = 0;
        clear_hash();
        for (int i = 0; i < 64; i++)
            blk_buf[i] = 8'h00;

        // empty message, "abc", byte extremes, a finish with stray data bits
        dir_tab.push_back('{REQ_FINISH, 8'h00, 1, EMPTY_W0});
        dir_tab.push_back('{REQ_ABSORB, 8'h61, 0, 0});
        dir_tab.push_back('{REQ_ABSORB, 8'h62, 0, 0});
        dir_tab.push_back('{REQ_ABSORB, 8'h63, 0, 0});
        dir_tab.push_back('{REQ_FINISH, 8'hff, 1, 32'hba7816bf});
        dir_tab.push_back('{REQ_ABSORB, 8'h00, 0, 0});
        dir_tab.push_back('{REQ_ABSORB, 8'hff, 0, 0});
        dir_tab.push_back('{REQ_ABSORB, 8'h55, 0, 0});
        dir_tab.push_back('{REQ_ABSORB, 8'haa, 0, 0});
        dir_tab.push_back('{REQ_FINISH, 8'h5a, 0, 0});
        dir_tab.push_back('{REQ_FINISH, 8'ha5, 1, EMPTY_W0});

        @(posedge rst_n);
        @(posedge clk);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].m == REQ_FINISH)
            begin
                typed_chk.push_back(dir_tab[i].has_w0);
                typed_w0.push_back(dir_tab[i].w0);
            end
            send_req(dir_tab[i].m, dir_tab[i].b);
        end

        // messages of 55, 56, 63, 64 and 65 bytes cross the padding boundaries
        for (int k = 0; k < 5; k++)
        begin
            len = EDGE_LENS[k];
            for (int j = 0; j < len; j++)
                send_req(REQ_ABSORB, 8'($urandom));
            typed_chk.push_back(0);
            typed_w0.push_back(0);
            send_req(REQ_FINISH, 8'($urandom));
        end

        // sender holds off until every digest word is back
        wait_drained();

        // random messages, mostly short
        n_items = 0;
        while (n_items < 80)
        begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(50, 130) : $urandom_range(0, 20);
            for (int j = 0; j < len; j++)
                send_req(REQ_ABSORB, 8'($urandom));
            typed_chk.push_back(0);
            typed_w0.push_back(0);
            send_req(REQ_FINISH, 8'($urandom));
            n_items += len + 1;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_cnt == 0)
            $display("sha256_stream_hasher_top verification clean");
        else
            $display("sha256_stream_hasher_top verification failed");
        $finish;
    end

    // receiver with a drawn wait before each word, and the digest check
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        stall = $urandom_range(0, 19);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                digest_rec_t got, want;
                got = '{out_ch.digest_word, out_ch.word_index, out_ch.last_word};
                stall = $urandom_range(0, 19);
                if (digest_q.size() == 0)
                begin
                    $display("%0t unexpected digest word: expected none actual %h", $time, got);
                    fail_cnt++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (got.digest_word !== want.digest_word)
                    begin
                        $display("%0t digest_word: expected %h actual %h",
                                 $time, want.digest_word, got.digest_word);
                        fail_cnt++;
                    end
                    if (got.word_index !== want.word_index)
                    begin
                        $display("%0t word_index: expected %0d actual %0d",
                                 $time, want.word_index, got.word_index);
                        fail_cnt++;
                    end
                    if (got.last_word !== want.last_word)
                    begin
                        $display("%0t last_word: expected %b actual %b",
                                 $time, want.last_word, got.last_word);
                        fail_cnt++;
                    end
                    // typed-in first words from the directed table
                    if (got.word_index == 0 && typed_chk.size() != 0)
                    begin
                        if (typed_chk.pop_front() && got.digest_word !== typed_w0[0])
                        begin
                            $display("%0t known digest: expected %h actual %h",
                                     $time, typed_w0[0], got.digest_word);
                            fail_cnt++;
                        end
                        void'(typed_w0.pop_front());
                    end
                end
            end
            else if (stall != 0)
            begin
                stall--;
            end
            out_ch.ready <= (stall == 0);
        end
    end

    // overall time limit
    initial
    begin
        #50ms;
        $display("sha256_stream_hasher_top verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/sha256s_pkg.sv
rtl/core/sha256s_in_if.sv
rtl/core/sha256s_out_if.sv
rtl/core/sha256_stream_hasher_top.sv
bench/tb_sha256s_types.sv
bench/tb_top.sv
